// ----- design/vfpn_pkg.sv -----
// Package for the view frustum plane normal unit: fixed-point widths,
// plane codes, lane and side-band types, output saturation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vfpn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ROT_W      = 18;
    localparam int SCALE_W    = 24;
    localparam int OUT_W      = 18;
    localparam int IDX_W      = 3;
    localparam int NUM_PLANES = 5;

    // input packing
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 56;

    // root search: result t in [0, 2^(F+1)], one bit per stage
    localparam int NSTEP = FRAC_BITS + 2;
    localparam int TW    = NSTEP;
    localparam int MAGW  = SCALE_W;
    localparam int PW    = 2 * MAGW + 2 * FRAC_BITS + 6;
    // 9 rotation components, then s, c, sv, cv
    localparam int NL    = 13;
    localparam int NROT  = 9;
    localparam int L_S   = 9;
    localparam int L_C   = 10;
    localparam int L_SV  = 11;
    localparam int L_CV  = 12;

    localparam int NW    = FRAC_BITS + 2;
    localparam int PRW   = 2 * NW;
    localparam int SUMW  = PRW + 1;

    localparam logic [IDX_W-1:0] PL_NEAR   = 3'd0;
    localparam logic [IDX_W-1:0] PL_BOTTOM = 3'd1;
    localparam logic [IDX_W-1:0] PL_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] PL_LEFT   = 3'd3;
    localparam logic [IDX_W-1:0] PL_RIGHT  = 3'd4;

    localparam logic signed [SUMW-1:0] OUT_MAXV = SUMW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUMW-1:0] OUT_MINV = -SUMW'(1 << (OUT_W - 1));
    localparam logic signed [SUMW-1:0] HALF     = SUMW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [PW-1:0] p;   // t^2 * s
        logic [PW-1:0] q;   // t * s
        logic [PW-1:0] s;   // squared length
        logic [PW-1:0] a;   // component^2 * 4^(F+1)
        logic [TW-1:0] t;
    } t_lane;

    typedef struct packed {
        logic [NROT-1:0] neg;
        logic [NL-1:0]   zero;
        logic            ortho;
    } t_side;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUMW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAXV)      r = OUT_MAXV[OUT_W-1:0];
        else if (v < OUT_MINV) r = OUT_MINV[OUT_W-1:0];
        else                   r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/view_frustum_plane_normals_unit.sv -----
// Frustum plane normal unit: pipelined exact normalization of the view
// rotation rows and projection scales, then five plane normals per request.
// Depends on vfpn_pkg.
//
// channel | dir | handshake            | payload
// s       | in  | i_s_tvalid/o_s_tready | i_s_tdata (rotation, scales), i_s_tuser (ortho)
// m       | out | o_m_tvalid/i_m_tready | o_m_tdata (normal), o_m_tuser (plane), o_m_tlast
//
// The near plane of a request comes out first; the five planes follow one per cycle
// while i_m_tready is high. A new request enters every cycle until the pipeline
// fills; the single result channel then sets the sustained request rate.
// Root search: one result bit per stage over 13 lanes (NSTEP stages).
// Reset clears all valid bits. A result-side stall freezes every stage while r_vr is set.
`timescale 1ns / 1ps
`default_nettype none
module view_frustum_plane_normals_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // rot_00..rot_22 (18b each), scale_x (24b), scale_y (24b), zero pad
    input  wire  [vfpn_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // ortho_mode
    input  wire                              i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // normal_x, normal_y, normal_z (18b each), zero pad
    output logic [vfpn_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // plane_index
    output logic [vfpn_pkg::IDX_W-1:0]       o_m_tuser,
    output logic                             o_m_tlast
);
    import vfpn_pkg::*;

    logic en, load;

    // stage 1: magnitudes squared
    logic                  r1_v;
    logic [2*ROT_W-1:0]    r1_sq  [NROT];
    logic [2*MAGW-1:0]     r1_msq [2];
    logic [NROT-1:0]       r1_neg;
    logic                  r1_ortho;

    // stage 2 and root stages
    logic                  r_v  [NSTEP+1];
    t_lane                 r_rl [NSTEP+1][NL];
    t_side                 r_sd [NSTEP+1];

    // product stage
    logic                  r_vr;
    logic signed [NW-1:0]  r_fw  [3];
    logic signed [PRW-1:0] r_fsy [3];
    logic signed [PRW-1:0] r_ucy [3];
    logic signed [PRW-1:0] r_fsx [3];
    logic signed [PRW-1:0] r_rcx [3];

    // output serializer
    logic                  r_ov;
    logic [IDX_W-1:0]      r_idx;
    logic signed [OUT_W-1:0] r_pl  [NUM_PLANES][3];
    logic signed [OUT_W-1:0] n_pl  [NUM_PLANES][3];

    assign load = r_vr && (!r_ov || (i_m_tready && r_idx == PL_RIGHT));
    assign en   = !r_vr || load;
    assign o_s_tready = en;

    // ---------------- stage 1 ----------------
    logic [ROT_W-1:0] w_rmag [NROT];
    logic [MAGW-1:0]  w_smag [2];
    always_comb begin
        for (int i = 0; i < NROT; i++) begin
            w_rmag[i] = i_s_tdata[i*ROT_W+ROT_W-1] ? -i_s_tdata[i*ROT_W +: ROT_W]
                                                   :  i_s_tdata[i*ROT_W +: ROT_W];
        end
        for (int i = 0; i < 2; i++) begin
            w_smag[i] = i_s_tdata[NROT*ROT_W+i*SCALE_W+SCALE_W-1]
                      ? -i_s_tdata[NROT*ROT_W+i*SCALE_W +: SCALE_W]
                      :  i_s_tdata[NROT*ROT_W+i*SCALE_W +: SCALE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NROT; i++) begin
                r1_sq[i]  <= (2*ROT_W)'(w_rmag[i]) * (2*ROT_W)'(w_rmag[i]);
                r1_neg[i] <= i_s_tdata[i*ROT_W+ROT_W-1];
            end
            for (int i = 0; i < 2; i++) begin
                r1_msq[i] <= (2*MAGW)'(w_smag[i]) * (2*MAGW)'(w_smag[i]);
            end
            r1_ortho <= i_s_tuser;
        end
    end

    // ---------------- stage 2: lane setup ----------------
    t_lane n_rl0 [NL];
    t_side n_sd0;
    always_comb begin
        logic [PW-1:0] rsum;
        logic [PW-1:0] tsum;
        n_sd0.neg   = r1_neg;
        n_sd0.ortho = r1_ortho;
        n_sd0.zero  = '0;
        for (int r = 0; r < 3; r++) begin
            rsum = PW'(r1_sq[3*r]) + PW'(r1_sq[3*r+1]) + PW'(r1_sq[3*r+2]);
            for (int c = 0; c < 3; c++) begin
                n_rl0[3*r+c].p = '0;
                n_rl0[3*r+c].q = '0;
                n_rl0[3*r+c].t = '0;
                n_rl0[3*r+c].s = rsum;
                n_rl0[3*r+c].a = PW'(r1_sq[3*r+c]) << (2*FRAC_BITS+2);
                n_sd0.zero[3*r+c] = (r1_sq[3*r+c] == '0);
            end
        end
        // index 0 is scale_y (s, c), index 1 is scale_x (sv, cv)
        for (int k = 0; k < 2; k++) begin
            tsum = (PW'(1) << (2*FRAC_BITS)) + PW'(r1_msq[1-k]);
            n_rl0[L_S+2*k].p   = '0;
            n_rl0[L_S+2*k].q   = '0;
            n_rl0[L_S+2*k].t   = '0;
            n_rl0[L_S+2*k].s   = tsum;
            n_rl0[L_S+2*k].a   = PW'(1) << (4*FRAC_BITS+2);
            n_rl0[L_C+2*k].p   = '0;
            n_rl0[L_C+2*k].q   = '0;
            n_rl0[L_C+2*k].t   = '0;
            n_rl0[L_C+2*k].s   = tsum;
            n_rl0[L_C+2*k].a   = PW'(r1_msq[1-k]) << (2*FRAC_BITS+2);
            n_sd0.zero[L_C+2*k] = (r1_msq[1-k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rl[0] <= n_rl0;
            r_sd[0] <= n_sd0;
        end
    end

    // ---------------- root stages: largest t with t^2*s <= a ----------------
    for (genvar j = 0; j < NSTEP; j++) begin : g_root
        localparam int K = NSTEP - 1 - j;
        t_lane         n_l    [NL];
        logic [PW-1:0] w_cand [NL];
        always_comb begin
            for (int l = 0; l < NL; l++) begin
                n_l[l]    = r_rl[j][l];
                w_cand[l] = r_rl[j][l].p + (r_rl[j][l].q << (K+1))
                          + (r_rl[j][l].s << (2*K));
                if (w_cand[l] <= r_rl[j][l].a) begin
                    n_l[l].p    = w_cand[l];
                    n_l[l].q    = r_rl[j][l].q + (r_rl[j][l].s << K);
                    n_l[l].t[K] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rl[j+1] <= n_l;
                r_sd[j+1] <= r_sd[j];
            end
        end
    end

    // ---------------- product stage ----------------
    logic signed [NW-1:0] w_lo [NL];
    logic signed [NW-1:0] w_fw [3];
    logic signed [NW-1:0] w_up [3];
    logic signed [NW-1:0] w_rt [3];
    logic signed [NW-1:0] w_sy, w_cy, w_sx, w_cx;
    always_comb begin
        logic [TW:0] tl;
        for (int l = 0; l < NL; l++) begin
            tl = {1'b0, r_rl[NSTEP][l].t} + (TW+1)'(1);
            // round half up: (t+1)/2, never above 2^F
            w_lo[l] = r_sd[NSTEP].zero[l] ? '0 : $signed({1'b0, tl[FRAC_BITS+1:1]});
        end
        for (int i = 0; i < 3; i++) begin
            w_rt[i] = r_sd[NSTEP].neg[i]   ? -w_lo[i]   : w_lo[i];
            w_up[i] = r_sd[NSTEP].neg[3+i] ? -w_lo[3+i] : w_lo[3+i];
            w_fw[i] = r_sd[NSTEP].neg[6+i] ? w_lo[6+i]  : -w_lo[6+i];
        end
        if (r_sd[NSTEP].ortho) begin
            w_sy = '0;
            w_sx = '0;
            w_cy = NW'(1) << FRAC_BITS;
            w_cx = NW'(1) << FRAC_BITS;
        end else begin
            w_sy = w_lo[L_S];
            w_cy = w_lo[L_C];
            w_sx = w_lo[L_SV];
            w_cx = w_lo[L_CV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_fw[i]  <= w_fw[i];
                r_fsy[i] <= PRW'(w_fw[i]) * PRW'(w_sy);
                r_ucy[i] <= PRW'(w_up[i]) * PRW'(w_cy);
                r_fsx[i] <= PRW'(w_fw[i]) * PRW'(w_sx);
                r_rcx[i] <= PRW'(w_rt[i]) * PRW'(w_cx);
            end
        end
    end

    // ---------------- combine, round, saturate ----------------
    always_comb begin
        logic signed [SUMW-1:0] a, b, c, d;
        for (int i = 0; i < 3; i++) begin
            a = SUMW'(r_fsy[i]);
            b = SUMW'(r_ucy[i]);
            c = SUMW'(r_fsx[i]);
            d = SUMW'(r_rcx[i]);
            n_pl[PL_NEAR][i]   = sat_out(SUMW'(r_fw[i]));
            n_pl[PL_BOTTOM][i] = sat_out((a + b + HALF) >>> FRAC_BITS);
            n_pl[PL_TOP][i]    = sat_out((a - b + HALF) >>> FRAC_BITS);
            n_pl[PL_LEFT][i]   = sat_out((c + d + HALF) >>> FRAC_BITS);
            n_pl[PL_RIGHT][i]  = sat_out((c - d + HALF) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_pl <= n_pl;
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            for (int j = 0; j <= NSTEP; j++) r_v[j] <= 1'b0;
            r_vr  <= 1'b0;
            r_ov  <= 1'b0;
            r_idx <= PL_NEAR;
        end else begin
            if (en) begin
                r1_v <= i_s_tvalid;
                r_v[0] <= r1_v;
                for (int j = 0; j < NSTEP; j++) r_v[j+1] <= r_v[j];
                r_vr <= r_v[NSTEP];
            end
            if (load) begin
                r_ov  <= 1'b1;
                r_idx <= PL_NEAR;
            end else if (r_ov && i_m_tready) begin
                if (r_idx == PL_RIGHT) r_ov <= 1'b0;
                else                   r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_idx;
    assign o_m_tlast  = (r_idx == PL_RIGHT);
    assign o_m_tdata  = {(OUT_DATA_W-3*OUT_W)'(0), r_pl[r_idx][2], r_pl[r_idx][1],
                         r_pl[r_idx][0]};

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= PL_RIGHT) else $error("plane index out of range");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_vr && r_ov)) else $error("stall without a pending result");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !load) |=> !o_m_tvalid)
        else $error("result set repeated");
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_m_tvalid && o_m_tuser == PL_NEAR)) else $error("set did not start at near");
`endif
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for view_frustum_plane_normals_unit: drives rotation and
// scale requests on the input stream, predicts the five plane normals per request.
// Depends on vfpn_pkg and the unit under test.
`timescale 1ns / 1ps

typedef struct {
    logic signed [vfpn_pkg::ROT_W-1:0]   rot [9];
    logic signed [vfpn_pkg::SCALE_W-1:0] sx;
    logic signed [vfpn_pkg::SCALE_W-1:0] sy;
    logic                                ortho;
} camera_req_t;

typedef struct {
    logic [vfpn_pkg::IDX_W-1:0]        idx;
    logic signed [vfpn_pkg::OUT_W-1:0] nx, ny, nz;
    logic                              last;
} plane_t;

class plane_scoreboard;
    plane_t pending[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    // round(a * 2^F / sqrt(s)) exactly, by search on the half-step t = 2m-1
    function longint unit_ratio(longint unsigned a, longint unsigned s);
        logic [127:0] rhs, lhs;
        longint unsigned lo, hi, mid, t;
        if (s == 0 || a == 0) return 0;
        rhs = {64'd0, a * a} << (2 * vfpn_pkg::FRAC_BITS + 2);
        lo = 0;
        hi = 64'd1 << vfpn_pkg::FRAC_BITS;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            lhs = {64'd0, t * t} * {64'd0, s};
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function void unit_vec(input longint v [3], output longint o [3]);
        longint unsigned sq;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
        for (int i = 0; i < 3; i++) begin
            o[i] = unit_ratio(v[i] < 0 ? -v[i] : v[i], sq);
            if (v[i] < 0) o[i] = -o[i];
        end
    endfunction

    function void angle_pair(longint p, output longint sn, output longint cs);
        longint unsigned one, mag, sq;
        one = 64'd1 << vfpn_pkg::FRAC_BITS;
        mag = p < 0 ? -p : p;
        sq = one * one + mag * mag;
        sn = unit_ratio(one, sq);
        cs = unit_ratio(mag, sq);
    endfunction

    function logic signed [vfpn_pkg::OUT_W-1:0] clip(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[vfpn_pkg::OUT_W-1:0];
    endfunction

    // floor((a*s + b*c + half) / 2^F), then saturate
    function logic signed [vfpn_pkg::OUT_W-1:0] blend(longint a, longint s, longint b, longint c);
        longint v;
        v = a * s + b * c + (64'sd1 <<< (vfpn_pkg::FRAC_BITS - 1));
        return clip(v >>> vfpn_pkg::FRAC_BITS);
    endfunction

    function void note_request(camera_req_t r);
        longint r0[3], r1[3], r2[3], rt[3], up[3], fw[3];
        longint s, c, sv, cv;
        plane_t p [5];
        for (int i = 0; i < 3; i++) begin
            r0[i] = r.rot[i];
            r1[i] = r.rot[3 + i];
            r2[i] = r.rot[6 + i];
        end
        unit_vec(r0, rt);
        unit_vec(r1, up);
        unit_vec(r2, fw);
        for (int i = 0; i < 3; i++) fw[i] = -fw[i];
        if (r.ortho) begin
            s = 0;
            sv = 0;
            c = 64'sd1 <<< vfpn_pkg::FRAC_BITS;
            cv = c;
        end else begin
            angle_pair(r.sy, s, c);
            angle_pair(r.sx, sv, cv);
        end
        p[0].idx = vfpn_pkg::PL_NEAR;
        p[1].idx = vfpn_pkg::PL_BOTTOM;
        p[2].idx = vfpn_pkg::PL_TOP;
        p[3].idx = vfpn_pkg::PL_LEFT;
        p[4].idx = vfpn_pkg::PL_RIGHT;
        p[0].nx = clip(fw[0]);
        p[0].ny = clip(fw[1]);
        p[0].nz = clip(fw[2]);
        p[1].nx = blend(fw[0], s, up[0], c);
        p[1].ny = blend(fw[1], s, up[1], c);
        p[1].nz = blend(fw[2], s, up[2], c);
        p[2].nx = blend(fw[0], s, -up[0], c);
        p[2].ny = blend(fw[1], s, -up[1], c);
        p[2].nz = blend(fw[2], s, -up[2], c);
        p[3].nx = blend(fw[0], sv, rt[0], cv);
        p[3].ny = blend(fw[1], sv, rt[1], cv);
        p[3].nz = blend(fw[2], sv, rt[2], cv);
        p[4].nx = blend(fw[0], sv, -rt[0], cv);
        p[4].ny = blend(fw[1], sv, -rt[1], cv);
        p[4].nz = blend(fw[2], sv, -rt[2], cv);
        for (int k = 0; k < 5; k++) begin
            p[k].last = (k == 4);
            pending.push_back(p[k]);
        end
    endfunction

    function void check_result(plane_t got);
        plane_t exp_p;
        if (pending.size() == 0) begin
            $error("unexpected plane result, index %0d", got.idx);
            errors++;
            return;
        end
        exp_p = pending.pop_front();
        if (got.idx !== exp_p.idx) begin
            $error("plane_index: expected %0d, got %0d", exp_p.idx, got.idx);
            errors++;
        end
        if (got.nx !== exp_p.nx) begin
            $error("normal_x: expected %0d, got %0d", exp_p.nx, got.nx);
            errors++;
        end
        if (got.ny !== exp_p.ny) begin
            $error("normal_y: expected %0d, got %0d", exp_p.ny, got.ny);
            errors++;
        end
        if (got.nz !== exp_p.nz) begin
            $error("normal_z: expected %0d, got %0d", exp_p.nz, got.nz);
            errors++;
        end
        if (got.last !== exp_p.last) begin
            $error("last_plane: expected %0d, got %0d", exp_p.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import vfpn_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [IDX_W-1:0]      m_tuser;
    logic                  m_tlast;

    plane_scoreboard sb = new();
    bit  no_idle = 1'b0;
    int  results_seen = 0;

    always #4 i_clk = ~i_clk;

    view_frustum_plane_normals_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    task automatic send_request(camera_req_t r);
        if (!no_idle && $urandom_range(99) < 18) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_tdata = '0;
        for (int i = 0; i < 9; i++) s_tdata[i*ROT_W +: ROT_W] = r.rot[i];
        s_tdata[9*ROT_W +: SCALE_W]           = r.sx;
        s_tdata[9*ROT_W + SCALE_W +: SCALE_W] = r.sy;
        s_tuser  = r.ortho;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    function automatic camera_req_t fill(longint rv, longint sx, longint sy, bit ortho);
        camera_req_t r;
        for (int i = 0; i < 9; i++) r.rot[i] = rv[ROT_W-1:0];
        r.sx = sx[SCALE_W-1:0];
        r.sy = sy[SCALE_W-1:0];
        r.ortho = ortho;
        return r;
    endfunction

    function automatic camera_req_t random_request();
        camera_req_t r;
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(9) == 0) r.rot[i] = '0;
            else if ($urandom_range(1)) r.rot[i] = ROT_W'($urandom);
            else r.rot[i] = ROT_W'(int'($urandom_range(0, 131072)) - 65536);
        end
        // mostly camera-like scales, sometimes the full range
        r.sx = $urandom_range(3) == 0 ? SCALE_W'($urandom) :
               SCALE_W'($signed(24'($urandom_range(0, 1 << 19))) - (1 << 18));
        r.sy = $urandom_range(3) == 0 ? SCALE_W'($urandom) :
               SCALE_W'($signed(24'($urandom_range(0, 1 << 19))) - (1 << 18));
        r.ortho = ($urandom_range(3) == 0);
        return r;
    endfunction

    // stimulus
    initial begin
        camera_req_t r;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        send_request(fill(0, 0, 0, 0));
        send_request(fill(0, 0, 0, 1));
        send_request(fill(131071, 8388607, 8388607, 0));
        send_request(fill(-131072, -8388608, -8388608, 0));
        send_request(fill(-131072, 8388607, -8388608, 1));
        send_request(fill(1, 1, -1, 0));
        send_request(fill(-1, 65536, 65536, 0));
        send_request(fill(65536, -65536, 0, 0));
        // identity rotation, typical perspective
        r = fill(0, 65536, 113512, 0);
        r.rot[0] = 65536; r.rot[4] = 65536; r.rot[8] = 65536;
        send_request(r);
        r.ortho = 1'b1;
        send_request(r);
        // one zero row per request
        for (int z = 0; z < 3; z++) begin
            r = fill(-40000, 98304, -98304, 0);
            for (int i = 0; i < 3; i++) r.rot[3*z + i] = '0;
            send_request(r);
        end
        // single nonzero component rows
        r = fill(0, 0, 8388607, 0);
        r.rot[2] = -131072; r.rot[3] = 131071; r.rot[7] = 1;
        send_request(r);
        r = fill(0, -1, 0, 0);
        r.rot[1] = 1; r.rot[5] = -1; r.rot[6] = -131072;
        send_request(r);
        for (int n = 0; n < 420; n++) begin
            no_idle = (n >= 250 && n < 330);
            if (n == 200) begin
                s_tvalid = 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            send_request(random_request());
        end
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // result side ready, with one long hold-off to back the pipeline up
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 100) begin
                held = 1'b1;
                m_tready = 1'b0;
                repeat (300) @(negedge i_clk);
            end
            m_tready = no_idle || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        plane_t got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.idx  = m_tuser;
            got.nx   = m_tdata[0 +: OUT_W];
            got.ny   = m_tdata[OUT_W +: OUT_W];
            got.nz   = m_tdata[2*OUT_W +: OUT_W];
            got.last = m_tlast;
            sb.check_result(got);
            results_seen++;
        end
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
